[design/sht_pkg.sv]
// Shared types, constants and helper function of the stereo harmonic tremolo.
package sht_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int LP_BITS     = 32;
   localparam int EXTRA_BITS  = LP_BITS - SAMPLE_BITS;
   localparam int LFO_BITS    = 16;
   localparam int DEPTH_BITS  = 16;
   localparam int GAIN_BITS   = 17;
   localparam int MUL_A_BITS  = LP_BITS + 2;
   localparam int MUL_B_BITS  = GAIN_BITS + 1;
   localparam int ACC_BITS    = MUL_A_BITS + MUL_B_BITS;
   localparam int SAT_BITS    = 36;

   localparam logic [GAIN_BITS-1:0] ALPHA_Q16 = 17'd6003;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 17'd65536;
   localparam logic [GAIN_BITS-1:0] LFO_HALF  = 17'd32768;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [LFO_BITS-1:0]    lfo_type;
   typedef logic [DEPTH_BITS-1:0]         depth_type;
   typedef logic [1:0]                    mode_type;
   typedef logic [1:0]                    csr_index_type;
   typedef logic [DEPTH_BITS-1:0]         csr_data_type;

   localparam mode_type MODE_TUBE      = 2'd0;
   localparam mode_type MODE_HARMONIC  = 2'd1;
   localparam mode_type MODE_PHOTO     = 2'd2;

   localparam csr_index_type CSR_MODE  = 2'd0;
   localparam csr_index_type CSR_DEPTH = 2'd1;

   localparam mode_type  MODE_RESET  = MODE_TUBE;
   localparam depth_type DEPTH_RESET = 16'd32768;

   // Clamp a wide signed value into the sample range.
   function automatic sample_type saturate(input logic signed [SAT_BITS-1:0] value);
      logic signed [SAT_BITS-1:0] hi;
      logic signed [SAT_BITS-1:0] lo;
      hi = SAT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
      lo = -hi - SAT_BITS'(1);
      if (value > hi) begin
         saturate = hi[SAMPLE_BITS-1:0];
      end else if (value < lo) begin
         saturate = lo[SAMPLE_BITS-1:0];
      end else begin
         saturate = value[SAMPLE_BITS-1:0];
      end
   endfunction

endpackage

[design/sht_if.sv]
// Valid/ready channel interfaces for the tremolo's sample and result streams.
interface sht_req_if;
   import sht_pkg::*;
   logic       valid;
   logic       ready;
   sample_type left_in;
   sample_type right_in;
   lfo_type    lfo_value;
   modport source (output valid, left_in, right_in, lfo_value, input ready);
   modport sink   (input valid, left_in, right_in, lfo_value, output ready);
endinterface

interface sht_rsp_if;
   import sht_pkg::*;
   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

[design/stereo_harmonic_tremolo.sv]
// Stereo harmonic tremolo: amplitude or band-crossover modulation of a stereo stream.
//
// Each transfer on the request channel carries a stereo Q1.23 sample pair and a Q1.15
// modulation value; one stereo pair comes back on the response channel per request.
// All arithmetic runs through a single signed 34x18 multiply-accumulate unit under a
// step counter, which runs from STEP_0 to STEP_4 in the amplitude modes (mode 0, 2 and
// the unused code 3) and from STEP_0 to STEP_8 in the harmonic mode (mode 1). The
// amplitude modes step through the two gain products, the two sample products and the
// loading of the response. The harmonic mode steps through the two gain products, the two
// lowpass updates, the product pair of each channel and the loading of the response.
// The request channel is not ready while a sample is being worked on and opens again in
// the cycle after the last step, so a new request is only taken once the previous one
// is through its last step.
// The response sits in an output register, so a new request can be taken and computed
// while the previous response waits; only the final step stalls until that response has
// been taken.
// Mode and depth are written through the csr_ port and must only change while idle.
// The lowpass state survives mode changes and is only updated in the harmonic mode.
module stereo_harmonic_tremolo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  sht_pkg::csr_index_type csr_index,
   input  sht_pkg::csr_data_type csr_wdata,
   sht_req_if.sink               req_port,
   sht_rsp_if.source             rsp_port
);
   import sht_pkg::*;

   // Step codes of the sequencer. Amplitude modes finish at STEP_4.
   localparam logic [3:0] STEP_0 = 4'd0;
   localparam logic [3:0] STEP_1 = 4'd1;
   localparam logic [3:0] STEP_2 = 4'd2;
   localparam logic [3:0] STEP_3 = 4'd3;
   localparam logic [3:0] STEP_4 = 4'd4;
   localparam logic [3:0] STEP_5 = 4'd5;
   localparam logic [3:0] STEP_6 = 4'd6;
   localparam logic [3:0] STEP_7 = 4'd7;
   localparam logic [3:0] STEP_8 = 4'd8;

   // Configuration registers.
   mode_type  mode_ff, mode_in;
   depth_type depth_ff, depth_in;

   // Sequencer control.
   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic       harm_ff, harm_in;

   // Latched request payload.
   sample_type xl_ff, xl_in;
   sample_type xr_ff, xr_in;
   lfo_type    lfo_ff, lfo_in;

   // Working registers.
   logic [GAIN_BITS-1:0]        g_lp_ff, g_lp_in;
   logic [GAIN_BITS-1:0]        g_hp_ff, g_hp_in;
   logic signed [LP_BITS-1:0]   lp_left_ff, lp_left_in;
   logic signed [LP_BITS-1:0]   lp_right_ff, lp_right_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   sample_type                  left_tmp_ff, left_tmp_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type left_out_ff, left_out_in;
   sample_type right_out_ff, right_out_in;

   // Shared multiplier and its operands.
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [ACC_BITS-1:0]   prod;
   logic                         acc_keep;

   logic                         last_step;
   logic                         advance;
   logic                         req_take;
   logic [GAIN_BITS-1:0]         u_val;
   logic [GAIN_BITS-1:0]         v_val;
   logic [GAIN_BITS-1:0]         gain_new;
   logic signed [LP_BITS-1:0]    xel;
   logic signed [LP_BITS-1:0]    xer;
   logic signed [MUL_A_BITS-1:0] diff_left;
   logic signed [MUL_A_BITS-1:0] diff_right;
   logic signed [ACC_BITS-1:0]   acc_shifted;
   sample_type                   acc_sat;

   assign req_port.ready = !busy_ff;
   assign req_take       = req_port.valid && !busy_ff;

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.left_out  = left_out_ff;
   assign rsp_port.right_out = right_out_ff;

   // u = 0.5 + 0.5m and v = 0.5 - 0.5m, both unsigned Q0.16 (v may reach 1.0).
   assign u_val = {1'b0, ~lfo_ff[LFO_BITS-1], lfo_ff[LFO_BITS-2:0]};
   assign v_val = LFO_HALF - GAIN_BITS'(lfo_ff);

   // The gain products d*u and d*v stay below 2^32, so bits 31:16 are the floor.
   assign gain_new = GAIN_ONE - {1'b0, acc_ff[31:16]};

   // Samples carried at the lowpass precision, and the high-band differences.
   assign xel = {xl_ff, EXTRA_BITS'(0)};
   assign xer = {xr_ff, EXTRA_BITS'(0)};
   assign diff_left  = MUL_A_BITS'(xel) - MUL_A_BITS'(lp_left_ff);
   assign diff_right = MUL_A_BITS'(xer) - MUL_A_BITS'(lp_right_ff);

   // Arithmetic shift is a floor; harmonic sums carry the extra fraction bits too.
   assign acc_shifted = harm_ff ? (acc_ff >>> (16 + EXTRA_BITS)) : (acc_ff >>> 16);
   assign acc_sat     = saturate(acc_shifted[SAT_BITS-1:0]);

   assign prod = mul_a * mul_b;

   assign last_step = harm_ff ? (step_ff == STEP_8) : (step_ff == STEP_4);
   // The final step waits while an earlier response still sits unread.
   assign advance   = busy_ff && (!last_step || !rsp_valid_ff || rsp_port.ready);

   // Operand selection for the shared multiply-accumulate unit.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      acc_keep = 1'b0;
      case (step_ff)
         STEP_0: begin
            mul_a = MUL_A_BITS'({1'b0, depth_ff});
            mul_b = MUL_B_BITS'({1'b0, u_val});
         end
         STEP_1: begin
            mul_a = MUL_A_BITS'({1'b0, depth_ff});
            mul_b = MUL_B_BITS'({1'b0, v_val});
         end
         STEP_2: begin
            if (harm_ff) begin
               mul_a = diff_left;
               mul_b = MUL_B_BITS'({1'b0, ALPHA_Q16});
            end else begin
               mul_a = MUL_A_BITS'(xl_ff);
               mul_b = MUL_B_BITS'({1'b0, g_lp_ff});
            end
         end
         STEP_3: begin
            if (harm_ff) begin
               mul_a = diff_right;
               mul_b = MUL_B_BITS'({1'b0, ALPHA_Q16});
            end else begin
               mul_a = MUL_A_BITS'(xr_ff);
               mul_b = MUL_B_BITS'({1'b0, g_lp_ff});
            end
         end
         STEP_4: begin
            mul_a = MUL_A_BITS'(lp_left_ff);
            mul_b = MUL_B_BITS'({1'b0, g_lp_ff});
         end
         STEP_5: begin
            mul_a    = diff_left;
            mul_b    = MUL_B_BITS'({1'b0, g_hp_ff});
            acc_keep = 1'b1;
         end
         STEP_6: begin
            mul_a = MUL_A_BITS'(lp_right_ff);
            mul_b = MUL_B_BITS'({1'b0, g_lp_ff});
         end
         STEP_7: begin
            mul_a    = diff_right;
            mul_b    = MUL_B_BITS'({1'b0, g_hp_ff});
            acc_keep = 1'b1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer and datapath register updates.
   always_comb begin
      mode_in      = mode_ff;
      depth_in     = depth_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      harm_in      = harm_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      lfo_in       = lfo_ff;
      g_lp_in      = g_lp_ff;
      g_hp_in      = g_hp_ff;
      lp_left_in   = lp_left_ff;
      lp_right_in  = lp_right_ff;
      acc_in       = acc_ff;
      left_tmp_in  = left_tmp_ff;
      rsp_valid_in = rsp_valid_ff;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_DEPTH: depth_in = csr_wdata;
            default:   mode_in  = mode_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_take) begin
         busy_in = 1'b1;
         step_in = STEP_0;
         harm_in = (mode_ff == MODE_HARMONIC);
         xl_in   = req_port.left_in;
         xr_in   = req_port.right_in;
         lfo_in  = req_port.lfo_value;
      end

      if (advance) begin
         acc_in  = (acc_keep ? acc_ff : '0) + prod;
         step_in = step_ff + 4'd1;
         case (step_ff)
            STEP_1: g_lp_in = gain_new;
            STEP_2: begin
               if (harm_ff) begin
                  g_hp_in = gain_new;
               end
            end
            STEP_3: begin
               if (harm_ff) begin
                  lp_left_in = lp_left_ff + acc_ff[LP_BITS+15:16];
               end else begin
                  left_tmp_in = acc_sat;
               end
            end
            STEP_4: begin
               if (harm_ff) begin
                  lp_right_in = lp_right_ff + acc_ff[LP_BITS+15:16];
               end
            end
            STEP_6: left_tmp_in = acc_sat;
            default: step_in = step_ff + 4'd1;
         endcase
         if (last_step) begin
            busy_in      = 1'b0;
            step_in      = STEP_0;
            rsp_valid_in = 1'b1;
            left_out_in  = left_tmp_ff;
            right_out_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         depth_ff     <= DEPTH_RESET;
         busy_ff      <= 1'b0;
         step_ff      <= STEP_0;
         harm_ff      <= 1'b0;
         lp_left_ff   <= '0;
         lp_right_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         harm_ff      <= harm_in;
         lp_left_ff   <= lp_left_in;
         lp_right_ff  <= lp_right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      lfo_ff       <= lfo_in;
      g_lp_ff      <= g_lp_in;
      g_hp_ff      <= g_hp_in;
      acc_ff       <= acc_in;
      left_tmp_ff  <= left_tmp_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

endmodule

[test/stereo_harmonic_tremolo_test.sv]
// Self-checking testbench for the stereo harmonic tremolo: random traffic against a predictor.
//
// A driver and a receiver, both clocked on the falling edge, move sample transfers into the
// block and result transfers out of it. A monitor on the rising edge sees every transfer. For
// each accepted sample pair it predicts the modulated pair and queues it. Each accepted result
// is then compared field by field with the oldest queued pair. Mode and depth are only
// rewritten while the block is idle, between phases of traffic.
module stereo_harmonic_tremolo_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sht_pkg::*;

   // Codes that the package does not name: the spare mode and the two register
   // indexes past the end of the register list.
   localparam mode_type      MODE_SPARE   = 2'd3;
   localparam csr_index_type CSR_SPARE_A  = 2'd2;
   localparam csr_index_type CSR_SPARE_B  = 2'd3;

   localparam sample_type SAMPLE_MAX = sample_type'(24'h7FFFFF);
   localparam sample_type SAMPLE_MIN = sample_type'(24'h800000);
   localparam lfo_type    LFO_MAX    = lfo_type'(16'h7FFF);
   localparam lfo_type    LFO_MIN    = lfo_type'(16'h8000);
   localparam lfo_type    LFO_ZERO   = lfo_type'(16'h0000);

   // The crossover lowpass coefficient and the extra fraction bits of its state.
   localparam longint LOWPASS_ALPHA  = 6003;
   localparam int     LOWPASS_EXTRA  = 8;
   localparam longint OUT_HIGH       = 64'sd8388607;
   localparam longint OUT_LOW        = -64'sd8388608;

   // BLOCK_CYCLES stands for the slowest request; settling waits beyond that.
   localparam int BLOCK_CYCLES       = 9;
   localparam int SETTLE_CYCLES      = BLOCK_CYCLES + 6;
   localparam int LONG_HOLD_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int PHASE_COUNT        = 12;
   localparam int PHASE_ITEMS        = 115;
   localparam int DEPTH_RANDOM       = -1;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_style_type;

   typedef struct {
      sample_type left;
      sample_type right;
      lfo_type    lfo;
      int         gap;
      bit         drain;
   } sample_item_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   logic          clock;
   logic          reset;
   logic          csr_write;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   sht_req_if req_if ();
   sht_rsp_if rsp_if ();

   stereo_harmonic_tremolo dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_port  (req_if),
      .rsp_port  (rsp_if)
   );

   // Pending sample items that the driver has not yet offered, and the modulated pairs
   // that the block still owes us, oldest first.
   sample_item_type pending_samples[$];
   stereo_pair_type expected_pairs[$];

   // Our own copy of the block's registers and crossover state.
   mode_type  mode_copy;
   depth_type depth_copy;
   longint    lowpass_left;
   longint    lowpass_right;

   // Transfer flags, set at each rising edge and read by the falling-edge processes.
   bit             req_fire;
   bit             rsp_fire;
   bit             offering;
   int             gap_count;
   int             stall_left;
   int             hold_left;
   int             hold_requests;
   int             hold_served;
   int             quiet_cycles;
   int             mismatch_count;
   idle_style_type idle_style;
   sample_type     last_left;
   sample_type     last_right;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sample_type clamp_sample(input longint value);
      if (value > OUT_HIGH) begin
         return SAMPLE_MAX;
      end
      if (value < OUT_LOW) begin
         return SAMPLE_MIN;
      end
      return sample_type'(value);
   endfunction

   // Works out the modulated pair for one transfer; harmonic mode also advances the lowpass.
   // Arithmetic shifts on signed 64-bit values give the floor division that the block uses.
   function automatic stereo_pair_type predict_tremolo_pair(input sample_type left,
                                                            input sample_type right,
                                                            input lfo_type lfo);
      stereo_pair_type pair;
      longint xl;
      longint xr;
      longint m;
      longint d;
      longint gain_low;
      longint gain_high;
      xl = left;
      xr = right;
      m = lfo;
      d = depth_copy;
      // The low band follows 0.5 + 0.5m and the high band follows 0.5 - 0.5m.
      gain_low = 65536 - ((d * (m + 32768)) >>> 16);
      gain_high = 65536 - ((d * (32768 - m)) >>> 16);
      if (mode_copy == MODE_HARMONIC) begin
         xl = xl <<< LOWPASS_EXTRA;
         xr = xr <<< LOWPASS_EXTRA;
         lowpass_left = lowpass_left + (((xl - lowpass_left) * LOWPASS_ALPHA) >>> 16);
         lowpass_right = lowpass_right + (((xr - lowpass_right) * LOWPASS_ALPHA) >>> 16);
         pair.left = clamp_sample((lowpass_left * gain_low + (xl - lowpass_left) * gain_high)
                                  >>> (16 + LOWPASS_EXTRA));
         pair.right = clamp_sample((lowpass_right * gain_low + (xr - lowpass_right) * gain_high)
                                   >>> (16 + LOWPASS_EXTRA));
      end else begin
         // Every other mode code, the spare one included, is a plain amplitude mode.
         if (gain_low < 0) begin
            gain_low = 0;
         end
         pair.left = clamp_sample((xl * gain_low) >>> 16);
         pair.right = clamp_sample((xr * gain_low) >>> 16);
      end
      return pair;
   endfunction

   task automatic note_mismatch(input string what, input sample_type got,
                                input sample_type want);
      mismatch_count++;
      $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
   endtask

   function automatic int draw_wait();
      case (idle_style)
         IDLE_NONE:  return 0;
         IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         default:    return $urandom_range(0, 15);
      endcase
   endfunction

   // Random sample values, biased toward the rails and toward holding the previous value,
   // so that the lowpass gets time to settle and saturation is reached.
   function automatic sample_type draw_sample(input sample_type previous);
      case ($urandom_range(0, 11))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return previous;
         4:       return sample_type'(int'($urandom_range(0, 511)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic lfo_type draw_lfo();
      case ($urandom_range(0, 9))
         0:       return LFO_MAX;
         1:       return LFO_MIN;
         2:       return LFO_ZERO;
         default: return lfo_type'($urandom);
      endcase
   endfunction

   task automatic push_sample(input sample_type left, input sample_type right,
                              input lfo_type lfo, input int gap, input bit drain);
      sample_item_type item;
      item.left = left;
      item.right = right;
      item.lfo = lfo;
      item.gap = gap;
      item.drain = drain;
      pending_samples.push_back(item);
   endtask

   // Waits until every pending item has been taken and every result has come back, then
   // waits out SETTLE_CYCLES so that the block is surely idle before a register is written.
   task automatic settle();
      while (pending_samples.size() != 0 || offering || expected_pairs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write, one cycle long. Our copy of the register follows the same rules
   // as the block: indexes past the end of the list change nothing.
   task automatic write_register(input csr_index_type index, input csr_data_type data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_MODE) begin
         mode_copy = mode_type'(data[1:0]);
      end else if (index == CSR_DEPTH) begin
         depth_copy = data;
      end
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         last_left = draw_sample(last_left);
         last_right = draw_sample(last_right);
         // Now and then the sender holds back until the block has returned everything.
         push_sample(last_left, last_right, draw_lfo(), draw_wait(),
                     (n == 50) || ($urandom_range(0, 39) == 0));
      end
      settle();
   endtask

   // Driver: offers one item at a time, waiting out each item's gap first. The valid line
   // gets exactly one nonblocking assignment per falling edge.
   always @(negedge clock) begin
      if (req_fire) begin
         offering = 1'b0;
      end
      if (!reset && !offering && pending_samples.size() != 0) begin
         if (gap_count < pending_samples[0].gap) begin
            gap_count++;
         end else if (!pending_samples[0].drain || expected_pairs.size() == 0) begin
            req_if.left_in <= pending_samples[0].left;
            req_if.right_in <= pending_samples[0].right;
            req_if.lfo_value <= pending_samples[0].lfo;
            void'(pending_samples.pop_front());
            offering = 1'b1;
            gap_count = 0;
         end
      end
      req_if.valid <= offering;
   end

   // Receiver: stalls for a drawn number of cycles after each result transfer, and holds
   // off for a long stretch whenever the stimulus asks for one.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (rsp_fire) begin
         stall_left = draw_wait();
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: predicts on every sample transfer, checks on every result transfer, and
   // ends the run if nothing has moved for too long.
   always @(posedge clock) begin
      stereo_pair_type want;
      stereo_pair_type got;
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;
      if (req_fire) begin
         expected_pairs.push_back(predict_tremolo_pair(req_if.left_in, req_if.right_in,
                                                       req_if.lfo_value));
      end
      if (rsp_fire) begin
         got.left = rsp_if.left_out;
         got.right = rsp_if.right_out;
         if (expected_pairs.size() == 0) begin
            note_mismatch("result with nothing pending, left_out", got.left, got.left);
         end else begin
            want = expected_pairs.pop_front();
            if (got.left !== want.left) begin
               note_mismatch("left_out", got.left, want.left);
            end
            if (got.right !== want.right) begin
               note_mismatch("right_out", got.right, want.right);
            end
         end
      end
      if (reset || req_fire || rsp_fire || csr_write) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stereo_harmonic_tremolo verification failed");
         $finish;
      end
   end

   initial begin
      mode_type       phase_mode[PHASE_COUNT];
      int             phase_depth[PHASE_COUNT];
      idle_style_type phase_idle[PHASE_COUNT];
      int             p;

      phase_mode  = '{MODE_HARMONIC, MODE_TUBE, MODE_HARMONIC, MODE_PHOTO, MODE_SPARE,
                      MODE_HARMONIC, MODE_TUBE, MODE_HARMONIC, MODE_PHOTO, MODE_HARMONIC,
                      MODE_TUBE, MODE_HARMONIC};
      phase_depth = '{DEPTH_RANDOM, 65535, 0, DEPTH_RANDOM, DEPTH_RANDOM, 65535, 0, 1,
                      65535, DEPTH_RANDOM, DEPTH_RANDOM, DEPTH_RANDOM};
      phase_idle  = '{IDLE_FULL, IDLE_NONE, IDLE_LIGHT, IDLE_FULL, IDLE_LIGHT, IDLE_FULL,
                      IDLE_FULL, IDLE_NONE, IDLE_LIGHT, IDLE_FULL, IDLE_FULL, IDLE_LIGHT};

      // Every input is known from time zero; reset is held at first and then released.
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_MODE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.left_in = '0;
      req_if.right_in = '0;
      req_if.lfo_value = '0;
      rsp_if.ready = 1'b0;
      mode_copy = MODE_RESET;
      depth_copy = DEPTH_RESET;
      lowpass_left = 0;
      lowpass_right = 0;
      offering = 1'b0;
      gap_count = 0;
      stall_left = 0;
      hold_left = 0;
      hold_requests = 0;
      hold_served = 0;
      quiet_cycles = 0;
      mismatch_count = 0;
      idle_style = IDLE_LIGHT;
      last_left = '0;
      last_right = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed part. First the reset setting, tube mode at half depth, at the rails
      // of the samples and of the modulation value, and just beside zero.
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_MAX, 0, 1'b0);
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_MIN, 1, 1'b0);
      push_sample(SAMPLE_MAX, SAMPLE_MAX, LFO_ZERO, 0, 1'b0);
      push_sample(sample_type'(-1), sample_type'(1), lfo_type'(-1), 3, 1'b0);
      settle();

      // Writes to the indexes past the register list must leave mode and depth alone.
      write_register(CSR_SPARE_A, csr_data_type'($urandom));
      write_register(CSR_SPARE_B, csr_data_type'($urandom));
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_MAX, 0, 1'b0);
      settle();

      // Full depth in tube mode: with the modulation at its top the gain nearly vanishes.
      write_register(CSR_DEPTH, csr_data_type'(16'hFFFF));
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_MAX, 0, 1'b0);
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_MIN, 0, 1'b0);
      settle();

      // Harmonic mode with no depth: both band gains are one, so the two bands add back
      // up to the input while the lowpass catches up with a full-scale step.
      write_register(CSR_MODE, csr_data_type'(MODE_HARMONIC));
      write_register(CSR_DEPTH, csr_data_type'(16'h0000));
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_ZERO, 0, 1'b0);
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_ZERO, 0, 1'b0);
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_MAX, 2, 1'b0);
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_MIN, 0, 1'b0);
      settle();

      // Harmonic mode at full depth swings the two bands in antiphase.
      write_register(CSR_DEPTH, csr_data_type'(16'hFFFF));
      push_sample(SAMPLE_MAX, SAMPLE_MAX, LFO_MAX, 0, 1'b0);
      push_sample(SAMPLE_MAX, SAMPLE_MAX, LFO_MIN, 0, 1'b0);
      push_sample(sample_type'(1000), sample_type'(-1000), LFO_ZERO, 0, 1'b0);
      settle();

      // The spare mode code acts as an amplitude mode; the photoresistor mode likewise.
      // The lowpass state must survive both and be picked up again later.
      write_register(CSR_MODE, csr_data_type'(MODE_SPARE));
      write_register(CSR_DEPTH, csr_data_type'(16'd40000));
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_MIN, 0, 1'b0);
      push_sample(sample_type'(12345), sample_type'(-54321), LFO_MAX, 0, 1'b0);
      settle();
      write_register(CSR_MODE, csr_data_type'(MODE_PHOTO));
      write_register(CSR_DEPTH, csr_data_type'(16'd1));
      push_sample(SAMPLE_MIN, SAMPLE_MAX, LFO_ZERO, 0, 1'b0);
      push_sample(SAMPLE_MAX, SAMPLE_MIN, LFO_MAX, 0, 1'b0);
      settle();

      // Random part: one phase per setting, each with its own idling style.
      for (p = 0; p < PHASE_COUNT; p++) begin
         idle_style = phase_idle[p];
         write_register(CSR_MODE, csr_data_type'(phase_mode[p]));
         if (phase_depth[p] == DEPTH_RANDOM) begin
            write_register(CSR_DEPTH, csr_data_type'($urandom));
         end else begin
            write_register(CSR_DEPTH, csr_data_type'(phase_depth[p]));
         end
         if (p == 5) begin
            // The receiver holds off for a long stretch while items keep coming, so the
            // output register fills and the block stops taking samples.
            @(posedge clock);
            hold_requests++;
         end
         run_random(PHASE_ITEMS);
      end

      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("stereo_harmonic_tremolo verification clean");
      end else begin
         $display("stereo_harmonic_tremolo verification failed");
      end
      $finish;
   end

endmodule
